[design/mtgl_pkg.sv]
// ----------------------------------------------------------------------------
// mtgl_pkg
// Shared types and constants for the multibyte text glyph locator.
// ----------------------------------------------------------------------------
package mtgl_pkg;

    // Language modes
    localparam logic [1:0] MODE_ASCII = 2'd0;
    localparam logic [1:0] MODE_SJIS  = 2'd1;
    localparam logic [1:0] MODE_EUC   = 2'd2;
    localparam logic [1:0] MODE_GB    = 2'd3;

    // Font table codes
    localparam logic [1:0] TABLE_ASCII = 2'd0;
    localparam logic [1:0] TABLE_JP    = 2'd1;
    localparam logic [1:0] TABLE_CN    = 2'd2;

    // Glyph kind codes
    localparam logic [1:0] KIND_HALF  = 2'd0;
    localparam logic [1:0] KIND_SPLIT = 2'd1;
    localparam logic [1:0] KIND_CN    = 2'd2;

    // Byte ranges
    localparam logic [7:0] SJIS_LEAD1_LO = 8'h81;
    localparam logic [7:0] SJIS_LEAD1_HI = 8'h9f;
    localparam logic [7:0] SJIS_LEAD2_LO = 8'he0;
    localparam logic [7:0] SJIS_LEAD2_HI = 8'hfc;
    localparam logic [7:0] SJIS_TRL1_LO  = 8'h40;
    localparam logic [7:0] SJIS_TRL1_HI  = 8'h7e;
    localparam logic [7:0] SJIS_TRL2_LO  = 8'h80;
    localparam logic [7:0] SJIS_TRL2_HI  = 8'h9e;
    localparam logic [7:0] SJIS_TRL3_LO  = 8'h9f;
    localparam logic [7:0] EUC_LEAD_LO   = 8'h81;
    localparam logic [7:0] GB_LEAD_LO    = 8'ha1;
    localparam logic [7:0] DBL_LEAD_HI   = 8'hfe;
    localparam logic [7:0] ROW_BASE      = 8'ha1;
    localparam logic [7:0] NO_LEAD       = 8'h00;

    localparam int SJIS_SECOND_HALF_ROW = 62;
    localparam int SJIS_TRL2_CELL       = 63;
    localparam int ROW_CELLS            = 94;
    localparam int FULL_BASE            = 4096;
    localparam int FULL_SHIFT           = 5;   // 32 bytes per full glyph
    localparam int PEN_STEP             = 8;
    localparam logic [12:0] PEN_MAX     = 13'h1fff;

    // Decoded word handed from the decode stage to the offset stage
    typedef struct packed {
        logic              emit;
        logic              full;
        logic signed [9:0] row;
        logic signed [9:0] cell_idx;
        logic [7:0]        code;
        logic [1:0]        table_sel;
        logic [1:0]        kind;
        logic signed [13:0] column;
    } dec_t;

endpackage

[design/mtgl_decode.sv]
// ----------------------------------------------------------------------------
// mtgl_decode
// Classifies one byte against the pending lead byte and the language mode,
// and forms row/cell indices, table, kind and drawing column.
// ----------------------------------------------------------------------------
module mtgl_decode (
    input  logic [1:0]      mode,
    input  logic [7:0]      lead,
    input  logic [7:0]      code,
    input  logic [12:0]     pen,
    output mtgl_pkg::dec_t  dec,
    output logic [7:0]      lead_next
);

    logic signed [9:0]  bs;
    logic signed [9:0]  ls;
    logic signed [13:0] pen_s;
    logic               sjis_lead;
    logic               dbl_lead;
    logic [7:0]         dbl_lo;

    assign bs    = $signed({2'b00, code});
    assign ls    = $signed({2'b00, lead});
    assign pen_s = $signed({1'b0, pen});

    assign sjis_lead = (code >= mtgl_pkg::SJIS_LEAD1_LO && code <= mtgl_pkg::SJIS_LEAD1_HI)
                    || (code >= mtgl_pkg::SJIS_LEAD2_LO && code <= mtgl_pkg::SJIS_LEAD2_HI);
    assign dbl_lo    = (mode == mtgl_pkg::MODE_EUC) ? mtgl_pkg::EUC_LEAD_LO
                                                    : mtgl_pkg::GB_LEAD_LO;
    assign dbl_lead  = (code >= dbl_lo) && (code <= mtgl_pkg::DBL_LEAD_HI);

    // Decode per language mode
    always_comb
    begin
        dec.emit      = 1'b1;
        dec.full      = 1'b0;
        dec.row       = '0;
        dec.cell_idx  = '0;
        dec.code      = code;
        dec.table_sel = mtgl_pkg::TABLE_ASCII;
        dec.kind      = mtgl_pkg::KIND_HALF;
        dec.column    = pen_s;
        lead_next     = lead;
        case (mode)
            mtgl_pkg::MODE_ASCII:
            begin
                dec.table_sel = mtgl_pkg::TABLE_ASCII;
            end
            mtgl_pkg::MODE_SJIS:
            begin
                dec.table_sel = mtgl_pkg::TABLE_JP;
                if (lead == mtgl_pkg::NO_LEAD)
                begin
                    if (sjis_lead)
                    begin
                        dec.emit  = 1'b0;
                        lead_next = code;
                    end
                end
                else
                begin
                    // row from lead: two rows per lead byte
                    if (lead >= mtgl_pkg::SJIS_LEAD1_LO && lead <= mtgl_pkg::SJIS_LEAD1_HI)
                        dec.row = (ls - 10'sd129) <<< 1;
                    else
                        dec.row = ((ls - 10'sd224) <<< 1)
                                + 10'(mtgl_pkg::SJIS_SECOND_HALF_ROW);
                    // cell from trail byte, odd/even row pick
                    if (code >= mtgl_pkg::SJIS_TRL1_LO && code <= mtgl_pkg::SJIS_TRL1_HI)
                        dec.cell_idx = bs - 10'sd64;
                    else if (code >= mtgl_pkg::SJIS_TRL2_LO && code <= mtgl_pkg::SJIS_TRL2_HI)
                        dec.cell_idx = bs - 10'sd128 + 10'(mtgl_pkg::SJIS_TRL2_CELL);
                    else
                    begin
                        dec.cell_idx = bs - 10'sd159;
                        dec.row  = ((lead >= mtgl_pkg::SJIS_LEAD1_LO
                                     && lead <= mtgl_pkg::SJIS_LEAD1_HI)
                                    ? ((ls - 10'sd129) <<< 1)
                                    : (((ls - 10'sd224) <<< 1)
                                       + 10'(mtgl_pkg::SJIS_SECOND_HALF_ROW)))
                                 + 10'sd1;
                    end
                    dec.full   = 1'b1;
                    dec.kind   = mtgl_pkg::KIND_SPLIT;
                    dec.column = pen_s - 14'sd8;
                    lead_next  = mtgl_pkg::NO_LEAD;
                end
            end
            mtgl_pkg::MODE_EUC, mtgl_pkg::MODE_GB:
            begin
                dec.table_sel = (mode == mtgl_pkg::MODE_EUC) ? mtgl_pkg::TABLE_JP
                                                             : mtgl_pkg::TABLE_CN;
                if (lead == mtgl_pkg::NO_LEAD)
                begin
                    if (dbl_lead)
                    begin
                        dec.emit  = 1'b0;
                        lead_next = code;
                    end
                end
                else
                begin
                    dec.row      = ls - $signed({2'b00, mtgl_pkg::ROW_BASE});
                    dec.cell_idx = bs - $signed({2'b00, mtgl_pkg::ROW_BASE});
                    dec.full     = 1'b1;
                    dec.kind     = (mode == mtgl_pkg::MODE_EUC) ? mtgl_pkg::KIND_SPLIT
                                                                : mtgl_pkg::KIND_CN;
                    dec.column   = pen_s - 14'sd8;
                    lead_next    = mtgl_pkg::NO_LEAD;
                end
            end
            default:
            begin
                dec.emit = 1'b0;
            end
        endcase
    end

endmodule

[design/mtgl_offset.sv]
// ----------------------------------------------------------------------------
// mtgl_offset
// Forms the byte offset of a glyph bitmap: code*16 for half-width glyphs,
// 4096 + (row*94 + cell_idx)*32 for full-width glyphs, wrapped to 20 bits.
// ----------------------------------------------------------------------------
module mtgl_offset (
    input  logic               full,
    input  logic signed [9:0]  row,
    input  logic signed [9:0]  cell_idx,
    input  logic [7:0]         code,
    output logic signed [19:0] offset
);

    logic signed [21:0] row_x;
    logic signed [21:0] index;
    logic signed [21:0] full_off;

    // constant multiply by the row width
    assign row_x    = 22'(row) * 22'(mtgl_pkg::ROW_CELLS);
    assign index    = row_x + 22'(cell_idx);
    assign full_off = (index <<< mtgl_pkg::FULL_SHIFT) + 22'(mtgl_pkg::FULL_BASE);

    assign offset = full ? full_off[19:0] : $signed({8'h00, code, 4'h0});

endmodule

[design/multibyte_text_glyph_locator.sv]
// ----------------------------------------------------------------------------
// multibyte_text_glyph_locator
// Decodes a byte stream under the configured language mode into glyph
// bitmap locations and drawing columns.
// ----------------------------------------------------------------------------
// Each accepted byte's result word is registered in s1_reg, then in the output register.
// Throughput: one byte per cycle while the output is not stalled; a lead byte yields no word.
// Lead byte and pen x update at the accept edge, so bytes may follow
// back to back; two pipeline registers decouple input and output stalls.
// Reset clears language mode, pending lead, pen x and all valid flags.
// ----------------------------------------------------------------------------
module multibyte_text_glyph_locator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_byte,
    input  logic               first_of_string,
    input  logic [11:0]        start_x,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [19:0] glyph_offset,
    output logic [1:0]         font_table,
    output logic [1:0]         glyph_kind,
    output logic signed [13:0] column_x
);

    logic [1:0]         mode_reg;
    logic [7:0]         lead_reg;
    logic [7:0]         lead_next;
    logic [12:0]        pen_reg;
    logic [12:0]        pen_next;
    logic [12:0]        pen_cur;
    logic [13:0]        pen_sum;
    logic               accept;
    logic               s1_adv;
    logic               s1_valid_reg;
    mtgl_pkg::dec_t     dec;
    mtgl_pkg::dec_t     s1_reg;
    logic signed [19:0] offset;
    logic               out_valid_reg;
    logic signed [19:0] offset_reg;
    logic [1:0]         table_reg;
    logic [1:0]         kind_reg;
    logic signed [13:0] column_reg;

    // handshake
    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    // pen position with saturation
    assign pen_cur  = first_of_string ? {1'b0, start_x} : pen_reg;
    assign pen_sum  = {1'b0, pen_cur} + 14'(mtgl_pkg::PEN_STEP);
    assign pen_next = (pen_sum > {1'b0, mtgl_pkg::PEN_MAX}) ? mtgl_pkg::PEN_MAX
                                                           : pen_sum[12:0];

    mtgl_decode u_decode (
        .mode      (mode_reg),
        .lead      (lead_reg),
        .code      (char_byte),
        .pen       (pen_cur),
        .dec       (dec),
        .lead_next (lead_next)
    );

    mtgl_offset u_offset (
        .full     (s1_reg.full),
        .row      (s1_reg.row),
        .cell_idx (s1_reg.cell_idx),
        .code     (s1_reg.code),
        .offset   (offset)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= mtgl_pkg::MODE_ASCII;
            lead_reg      <= mtgl_pkg::NO_LEAD;
            pen_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (accept)
            begin
                lead_reg <= lead_next;
                pen_reg  <= pen_next;
            end
            if (in_ready)
                s1_valid_reg <= accept && dec.emit;
            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready)
            s1_reg <= dec;
        if (s1_adv)
        begin
            offset_reg <= offset;
            table_reg  <= s1_reg.table_sel;
            kind_reg   <= s1_reg.kind;
            column_reg <= s1_reg.column;
        end
    end

    assign out_valid    = out_valid_reg;
    assign glyph_offset = offset_reg;
    assign font_table   = table_reg;
    assign glyph_kind   = kind_reg;
    assign column_x     = column_reg;

endmodule

[design/mtgl_checker.sv]
// ----------------------------------------------------------------------------
// mtgl_checker
// Port-level checks for the multibyte text glyph locator.
// ----------------------------------------------------------------------------
module mtgl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [19:0] glyph_offset,
    input logic [1:0]         font_table,
    input logic [1:0]         glyph_kind,
    input logic signed [13:0] column_x
);

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(glyph_offset)
            && $stable(column_x))
        else $error("stalled output word changed");

    // empty output stage never blocks input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // bitmaps sit on 16-byte boundaries
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> glyph_offset[3:0] == 4'h0)
        else $error("glyph offset misaligned");

    // ascii font holds only half-width glyphs, drawn at a nonnegative column
    a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && font_table == mtgl_pkg::TABLE_ASCII
            |-> glyph_kind == mtgl_pkg::KIND_HALF && !column_x[13])
        else $error("ascii word with full-width kind or negative column");

endmodule

bind multibyte_text_glyph_locator mtgl_checker u_mtgl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .glyph_offset (glyph_offset),
    .font_table   (font_table),
    .glyph_kind   (glyph_kind),
    .column_x     (column_x)
);
